>>> rtl/core/rhc_pkg.sv
// Shared types, widths, constants and codes of the RGB hue color classifier.
package rhc_pkg;

  // Field widths
  localparam int RAW_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int CH_W    = 14;
  localparam int HUE_W   = 13;
  localparam int SAT_W   = 13;
  localparam int CLS_W   = 2;
  localparam int FRAC_W  = 12;
  localparam int PROD_W  = RAW_W + GAIN_W;

  // Divider geometry: one quotient bit per cell, remainder wide enough for delta << 12
  localparam int QUO_W     = 13;
  localparam int REM_W     = CH_W + FRAC_W;
  localparam int DIV_STEPS = QUO_W;

  // Hue constants in 1/16 degree units
  localparam int HUE_SECTOR = 960;
  localparam int HUE_FULL   = 5760;
  localparam int HSUM_W     = HUE_W + 1;

  // Configuration port
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int GAINS_W  = 3 * GAIN_W;
  localparam int IDX_W    = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GAINS   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RED_LO  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RED_HI  = 3'd2;
  localparam logic [IDX_W-1:0] REG_GRN_LO  = 3'd3;
  localparam logic [IDX_W-1:0] REG_GRN_HI  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLU_LO  = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLU_HI  = 3'd6;

  // Register reset values
  localparam logic [GAINS_W-1:0] GAINS_RST  = 48'h1000_1000_1000;
  localparam logic [HUE_W-1:0]   RED_LO_RST = 13'd480;
  localparam logic [HUE_W-1:0]   RED_HI_RST = 13'd5280;
  localparam logic [HUE_W-1:0]   GRN_LO_RST = 13'd1440;
  localparam logic [HUE_W-1:0]   GRN_HI_RST = 13'd2880;
  localparam logic [HUE_W-1:0]   BLU_LO_RST = 13'd2880;
  localparam logic [HUE_W-1:0]   BLU_HI_RST = 13'd4320;

  // Color class codes
  localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_RED   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_GREEN = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BLUE  = 2'd3;

  // Hue sector codes (which channel holds the maximum)
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Hue band bounds handed to the classifier
  typedef struct packed {
    logic [HUE_W-1:0] red_lo;
    logic [HUE_W-1:0] red_hi;
    logic [HUE_W-1:0] grn_lo;
    logic [HUE_W-1:0] grn_hi;
    logic [HUE_W-1:0] blu_lo;
    logic [HUE_W-1:0] blu_hi;
  } band_cfg_t;

  // Word passed from one divider cell to the next
  typedef struct packed {
    logic             vld;
    logic [REM_W-1:0] rem_s;   // saturation remainder
    logic [QUO_W-1:0] q_s;     // saturation quotient
    logic [REM_W-1:0] rem_h;   // hue remainder
    logic [CH_W-1:0]  dvs_h;   // hue divisor (delta)
    logic [QUO_W-1:0] q_h;     // hue quotient
    logic [1:0]       sector;
    logic             neg;
    logic             zero;
    logic [CH_W-1:0]  mx;      // saturation divisor and brightness
  } div_cell_t;

  // Sector base hue
  function automatic logic [HSUM_W-1:0] sector_base(input logic [1:0] sec);
    logic [HSUM_W-1:0] base;
    case (sec)
      SEC_RED:   base = HSUM_W'(0);
      SEC_GREEN: base = HSUM_W'(2 * HUE_SECTOR);
      SEC_BLUE:  base = HSUM_W'(4 * HUE_SECTOR);
      default:   base = HSUM_W'(0);
    endcase
    return base;
  endfunction

endpackage

>>> rtl/core/rhc_front.sv
// Front end: channel gain scaling, max/min/delta, sector pick and divider operands.
module rhc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  logic [rhc_pkg::RAW_W-1:0]          raw_red,
  input  logic [rhc_pkg::RAW_W-1:0]          raw_green,
  input  logic [rhc_pkg::RAW_W-1:0]          raw_blue,
  input  logic [rhc_pkg::GAINS_W-1:0]        gains,
  output rhc_pkg::div_cell_t                 cell_o
);

  localparam int RW = rhc_pkg::RAW_W;
  localparam int GW = rhc_pkg::GAIN_W;
  localparam int PW = rhc_pkg::PROD_W;
  localparam int CW = rhc_pkg::CH_W;
  localparam int FW = rhc_pkg::FRAC_W;
  localparam int MW = rhc_pkg::REM_W;
  localparam int QW = rhc_pkg::QUO_W;
  localparam int NW = CW + 10;   // width of 960 * diff

  // Scale stage
  logic [PW-1:0] prod_red, prod_grn, prod_blu;
  logic          a_vld_r;
  logic [CW-1:0] a_red_r, a_grn_r, a_blu_r;

  assign prod_red = {{GW{1'b0}}, raw_red}   * {{RW{1'b0}}, gains[GW-1:0]};
  assign prod_grn = {{GW{1'b0}}, raw_green} * {{RW{1'b0}}, gains[2*GW-1:GW]};
  assign prod_blu = {{GW{1'b0}}, raw_blue}  * {{RW{1'b0}}, gains[3*GW-1:2*GW]};

  // Truncate the Q14.12 products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    a_red_r <= prod_red[PW-1:FW];
    a_grn_r <= prod_grn[PW-1:FW];
    a_blu_r <= prod_blu[PW-1:FW];
  end

  // Max/min stage; red wins ties over green, green over blue
  logic [CW-1:0] mx_nxt, mn_nxt, op_a, op_b;
  logic [1:0]    sec_nxt;
  logic          b_vld_r, b_neg_r;
  logic [CW-1:0] b_mx_r, b_delta_r, b_diff_r;
  logic [1:0]    b_sec_r;

  always_comb begin
    mx_nxt = a_red_r;
    if (a_grn_r > mx_nxt) mx_nxt = a_grn_r;
    if (a_blu_r > mx_nxt) mx_nxt = a_blu_r;
    mn_nxt = a_red_r;
    if (a_grn_r < mn_nxt) mn_nxt = a_grn_r;
    if (a_blu_r < mn_nxt) mn_nxt = a_blu_r;
    if (a_red_r == mx_nxt) begin
      sec_nxt = rhc_pkg::SEC_RED;
      op_a    = a_grn_r;
      op_b    = a_blu_r;
    end else if (a_grn_r == mx_nxt) begin
      sec_nxt = rhc_pkg::SEC_GREEN;
      op_a    = a_blu_r;
      op_b    = a_red_r;
    end else begin
      sec_nxt = rhc_pkg::SEC_BLUE;
      op_a    = a_red_r;
      op_b    = a_grn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_mx_r    <= mx_nxt;
    b_delta_r <= mx_nxt - mn_nxt;
    b_neg_r   <= (op_a < op_b);
    b_diff_r  <= (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    b_sec_r   <= sec_nxt;
  end

  // Operand stage: delta << 12 over max, 960 * diff over delta
  logic [NW-1:0] hue_num;
  logic          c_vld_r;
  rhc_pkg::div_cell_t c_cell_r;

  assign hue_num = {b_diff_r, 10'b0} - {4'b0, b_diff_r, 6'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_cell_r.vld    <= 1'b0;
    c_cell_r.rem_s  <= {b_delta_r, {FW{1'b0}}};
    c_cell_r.q_s    <= '0;
    c_cell_r.rem_h  <= {{(MW-NW){1'b0}}, hue_num};
    c_cell_r.dvs_h  <= b_delta_r;
    c_cell_r.q_h    <= {QW{1'b0}};
    c_cell_r.sector <= b_sec_r;
    c_cell_r.neg    <= b_neg_r;
    c_cell_r.zero   <= (b_delta_r == '0);
    c_cell_r.mx     <= b_mx_r;
  end

  always_comb begin
    cell_o     = c_cell_r;
    cell_o.vld = c_vld_r;
  end

endmodule

>>> rtl/core/rhc_div_cell.sv
// Divider cell: one restoring step for both the saturation and the hue quotient.
module rhc_div_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rhc_pkg::div_cell_t cell_i,
  output rhc_pkg::div_cell_t cell_o
);

  localparam int MW = rhc_pkg::REM_W;
  localparam int CW = rhc_pkg::CH_W;

  logic [MW-1:0]      sh_s, sh_h;
  rhc_pkg::div_cell_t cell_nxt;
  rhc_pkg::div_cell_t data_r;
  logic               vld_r;

  // Divisors aligned to this quotient bit
  assign sh_s = {{(MW-CW){1'b0}}, cell_i.mx}    << STEP;
  assign sh_h = {{(MW-CW){1'b0}}, cell_i.dvs_h} << STEP;

  // Subtract where the aligned divisor fits
  always_comb begin
    cell_nxt = cell_i;
    if (cell_i.rem_s >= sh_s) begin
      cell_nxt.rem_s   = cell_i.rem_s - sh_s;
      cell_nxt.q_s[STEP] = 1'b1;
    end
    if (cell_i.rem_h >= sh_h) begin
      cell_nxt.rem_h   = cell_i.rem_h - sh_h;
      cell_nxt.q_h[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= cell_nxt;
  end

  always_comb begin
    cell_o     = data_r;
    cell_o.vld = vld_r;
  end

endmodule

>>> rtl/core/rhc_back.sv
// Back end: hue assembly and wrap, grey handling, band classification and result register.
module rhc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rhc_pkg::div_cell_t            cell_i,
  input  rhc_pkg::band_cfg_t            bands,
  output logic                          out_valid,
  output logic [rhc_pkg::CLS_W-1:0]     out_color_class,
  output logic [rhc_pkg::HUE_W-1:0]     out_hue,
  output logic [rhc_pkg::SAT_W-1:0]     out_saturation,
  output logic [rhc_pkg::CH_W-1:0]      out_brightness
);

  localparam int SW = rhc_pkg::HSUM_W;
  localparam int HW = rhc_pkg::HUE_W;
  localparam int QW = rhc_pkg::QUO_W;
  localparam logic [SW-1:0] FULL = SW'(rhc_pkg::HUE_FULL);

  // Hue assembly stage
  logic [SW-1:0] base, qc, hsum, hwrap;
  logic          h_vld_r;
  logic [HW-1:0] h_hue_r;
  logic [QW-1:0] h_sat_r;
  logic [rhc_pkg::CH_W-1:0] h_mx_r;

  assign base = rhc_pkg::sector_base(cell_i.sector);

  // Negative side rounds the quotient up: bump it when a remainder is left
  always_comb begin
    qc = {{(SW-QW){1'b0}}, cell_i.q_h};
    if (cell_i.neg && (cell_i.rem_h != '0)) qc = qc + SW'(1);
    if (cell_i.neg) hsum = base + FULL - qc;
    else            hsum = base + qc;
    hwrap = (hsum >= FULL) ? (hsum - FULL) : hsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= cell_i.vld;
    end
  end

  // Grey or black: hue and saturation are zero
  always_ff @(posedge clk) begin
    h_hue_r <= cell_i.zero ? '0 : hwrap[HW-1:0];
    h_sat_r <= cell_i.zero ? '0 : cell_i.q_s;
    h_mx_r  <= cell_i.mx;
  end

  // Classification stage: red test first, then green, then blue
  logic [rhc_pkg::CLS_W-1:0] cls_nxt;
  logic                      valid_r;
  logic [rhc_pkg::CLS_W-1:0] cls_r;
  logic [HW-1:0]             hue_r;
  logic [QW-1:0]             sat_r;
  logic [rhc_pkg::CH_W-1:0]  bright_r;

  always_comb begin
    if (h_hue_r < bands.red_lo || h_hue_r > bands.red_hi) begin
      cls_nxt = rhc_pkg::CLS_RED;
    end else if (h_hue_r > bands.grn_lo && h_hue_r < bands.grn_hi) begin
      cls_nxt = rhc_pkg::CLS_GREEN;
    end else if (h_hue_r > bands.blu_lo && h_hue_r < bands.blu_hi) begin
      cls_nxt = rhc_pkg::CLS_BLUE;
    end else begin
      cls_nxt = rhc_pkg::CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    cls_r    <= cls_nxt;
    hue_r    <= h_hue_r;
    sat_r    <= h_sat_r;
    bright_r <= h_mx_r;
  end

  assign out_valid       = valid_r;
  assign out_color_class = cls_r;
  assign out_hue         = hue_r;
  assign out_saturation  = sat_r;
  assign out_brightness  = bright_r;

endmodule

>>> rtl/core/rgb_hue_color_classifier.sv
// Top level of the RGB hue color classifier: register port, front end, divider chain, back end.
// Path: a start transfer reaches out_valid through the scale, max/min and operand stages,
// the 13 divider cells, and the hue and classify stages.
// Throughput: one sample per cycle; busy stays low, the 13-cell divider chain is fully pipelined.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register reset values.
module rgb_hue_color_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  // Command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [rhc_pkg::RAW_W-1:0]      in_raw_red,
  input  logic [rhc_pkg::RAW_W-1:0]      in_raw_green,
  input  logic [rhc_pkg::RAW_W-1:0]      in_raw_blue,
  // Result channel
  output logic                           out_valid,
  output logic [rhc_pkg::CLS_W-1:0]      out_color_class,
  output logic [rhc_pkg::HUE_W-1:0]      out_hue,
  output logic [rhc_pkg::SAT_W-1:0]      out_saturation,
  output logic [rhc_pkg::CH_W-1:0]       out_brightness,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rhc_pkg::ADDR_W-1:0]     paddr,
  input  logic [rhc_pkg::DATA_W-1:0]     pwdata,
  output logic [rhc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam int DW = rhc_pkg::DATA_W;
  localparam int GW = rhc_pkg::GAINS_W;
  localparam int HW = rhc_pkg::HUE_W;
  localparam int NS = rhc_pkg::DIV_STEPS;
  localparam int IW = rhc_pkg::IDX_W;

  // Registers
  logic [GW-1:0] gains_r;
  logic [HW-1:0] red_lo_r, red_hi_r, grn_lo_r, grn_hi_r, blu_lo_r, blu_hi_r;
  logic          wr_en;
  logic [IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[rhc_pkg::ADDR_W-1:rhc_pkg::ADDR_W-IW];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write on the access cycle; indexes beyond the list drop the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r  <= rhc_pkg::GAINS_RST;
      red_lo_r <= rhc_pkg::RED_LO_RST;
      red_hi_r <= rhc_pkg::RED_HI_RST;
      grn_lo_r <= rhc_pkg::GRN_LO_RST;
      grn_hi_r <= rhc_pkg::GRN_HI_RST;
      blu_lo_r <= rhc_pkg::BLU_LO_RST;
      blu_hi_r <= rhc_pkg::BLU_HI_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rhc_pkg::REG_GAINS:  gains_r  <= pwdata[GW-1:0];
        rhc_pkg::REG_RED_LO: red_lo_r <= pwdata[HW-1:0];
        rhc_pkg::REG_RED_HI: red_hi_r <= pwdata[HW-1:0];
        rhc_pkg::REG_GRN_LO: grn_lo_r <= pwdata[HW-1:0];
        rhc_pkg::REG_GRN_HI: grn_hi_r <= pwdata[HW-1:0];
        rhc_pkg::REG_BLU_LO: blu_lo_r <= pwdata[HW-1:0];
        rhc_pkg::REG_BLU_HI: blu_hi_r <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      rhc_pkg::REG_GAINS:  prdata = {{(DW-GW){1'b0}}, gains_r};
      rhc_pkg::REG_RED_LO: prdata = {{(DW-HW){1'b0}}, red_lo_r};
      rhc_pkg::REG_RED_HI: prdata = {{(DW-HW){1'b0}}, red_hi_r};
      rhc_pkg::REG_GRN_LO: prdata = {{(DW-HW){1'b0}}, grn_lo_r};
      rhc_pkg::REG_GRN_HI: prdata = {{(DW-HW){1'b0}}, grn_hi_r};
      rhc_pkg::REG_BLU_LO: prdata = {{(DW-HW){1'b0}}, blu_lo_r};
      rhc_pkg::REG_BLU_HI: prdata = {{(DW-HW){1'b0}}, blu_hi_r};
      default:             prdata = '0;
    endcase
  end

  rhc_pkg::band_cfg_t bands;

  assign bands = '{red_lo: red_lo_r, red_hi: red_hi_r, grn_lo: grn_lo_r,
                   grn_hi: grn_hi_r, blu_lo: blu_lo_r, blu_hi: blu_hi_r};

  // Datapath
  rhc_pkg::div_cell_t link [NS+1];

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (start && !busy),
    .raw_red   (in_raw_red),
    .raw_green (in_raw_green),
    .raw_blue  (in_raw_blue),
    .gains     (gains_r),
    .cell_o    (link[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < NS; i++) begin : g_cell
    rhc_div_cell #(
      .STEP (NS - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  rhc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cell_i          (link[NS]),
    .bands           (bands),
    .out_valid       (out_valid),
    .out_color_class (out_color_class),
    .out_hue         (out_hue),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness)
  );

endmodule

>>> rtl/core/rhc_prop_chk.sv
// Port-level property checker for the RGB hue color classifier, with its bind.
module rhc_prop_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [rhc_pkg::HUE_W-1:0]  out_hue,
  input logic [rhc_pkg::SAT_W-1:0]  out_saturation
);

  localparam int LAT = 18;

  // Every accepted sample yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##18 out_valid)
    else $error("accepted sample produced no result");

  // No result without a sample accepted at the matching edge
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without a matching sample");

  // Hue stays wrapped and saturation within one
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < 13'd5760) && (out_saturation <= 13'd4096))
    else $error("hue or saturation out of range");

  // The command side is never held off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind rgb_hue_color_classifier rhc_prop_chk u_prop_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hue        (out_hue),
  .out_saturation (out_saturation)
);

>>> tb/tb.sv
// Testbench for the RGB hue color classifier: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import rhc_pkg::*;

  typedef int unsigned u32_t;

  // Index past the end of the register list; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int REPORT_MAX = 10;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic [RAW_W-1:0] r;
    logic [RAW_W-1:0] g;
    logic [RAW_W-1:0] b;
    u32_t             gap;
  } sample_t;

  typedef struct {
    logic [CLS_W-1:0] cls;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  bright;
  } hsv_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [RAW_W-1:0]  in_raw_red = '0;
  logic [RAW_W-1:0]  in_raw_green = '0;
  logic [RAW_W-1:0]  in_raw_blue = '0;
  logic              out_valid;
  logic [CLS_W-1:0]  out_color_class;
  logic [HUE_W-1:0]  out_hue;
  logic [SAT_W-1:0]  out_saturation;
  logic [CH_W-1:0]   out_brightness;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rgb_hue_color_classifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_raw_red      (in_raw_red),
    .in_raw_green    (in_raw_green),
    .in_raw_blue     (in_raw_blue),
    .out_valid       (out_valid),
    .out_color_class (out_color_class),
    .out_hue         (out_hue),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic [GAINS_W-1:0] gains_cfg;
  band_cfg_t          bands_cfg;

  sample_t     pending_samples[$];
  hsv_result_t expected_hsv[$];
  int          err_cnt = 0;

  sample_t cur_sample;
  logic    have_cur = 1'b0;
  u32_t    gap_left = 0;
  logic    took = 1'b0;

  task automatic note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("tb: error at %0t: %s", $realtime, msg);
  endtask

  // Model of one register write, keeping only the bits the register holds
  task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    case (idx)
      REG_GAINS:  gains_cfg = val[GAINS_W-1:0];
      REG_RED_LO: bands_cfg.red_lo = val[HUE_W-1:0];
      REG_RED_HI: bands_cfg.red_hi = val[HUE_W-1:0];
      REG_GRN_LO: bands_cfg.grn_lo = val[HUE_W-1:0];
      REG_GRN_HI: bands_cfg.grn_hi = val[HUE_W-1:0];
      REG_BLU_LO: bands_cfg.blu_lo = val[HUE_W-1:0];
      REG_BLU_HI: bands_cfg.blu_hi = val[HUE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic u32_t scaled_channel(input logic [RAW_W-1:0] raw,
                                          input logic [GAIN_W-1:0] gain);
    return (u32_t'(raw) * u32_t'(gain)) >> FRAC_W;
  endfunction

  // Sector base plus 960*(a-b)/delta rounded toward minus infinity, wrapped into one turn
  function automatic u32_t sector_hue(input u32_t base, input u32_t a, input u32_t b,
                                      input u32_t dl);
    u32_t h;
    if (a >= b) h = base + (HUE_SECTOR * (a - b)) / dl;
    else h = base + HUE_FULL - (HUE_SECTOR * (b - a) + dl - 1) / dl;
    if (h >= HUE_FULL) h = h - HUE_FULL;
    return h;
  endfunction

  function automatic hsv_result_t classify_sample(input logic [RAW_W-1:0] rr,
                                                  input logic [RAW_W-1:0] gg,
                                                  input logic [RAW_W-1:0] bb);
    u32_t        sr, sg, sb, mx, mn, dl, h, s;
    hsv_result_t res;
    sr = scaled_channel(rr, gains_cfg[15:0]);
    sg = scaled_channel(gg, gains_cfg[31:16]);
    sb = scaled_channel(bb, gains_cfg[47:32]);
    mx = sr;
    mn = sr;
    if (sg > mx) mx = sg;
    if (sb > mx) mx = sb;
    if (sg < mn) mn = sg;
    if (sb < mn) mn = sb;
    dl = mx - mn;
    h = 0;
    s = 0;
    if (dl != 0) begin
      s = (dl << FRAC_W) / mx;
      // Ties on the maximum: red first, then green
      if (sr == mx) h = sector_hue(0, sg, sb, dl);
      else if (sg == mx) h = sector_hue(2 * HUE_SECTOR, sb, sr, dl);
      else h = sector_hue(4 * HUE_SECTOR, sr, sg, dl);
    end
    if (h < bands_cfg.red_lo || h > bands_cfg.red_hi) res.cls = CLS_RED;
    else if (h > bands_cfg.grn_lo && h < bands_cfg.grn_hi) res.cls = CLS_GREEN;
    else if (h > bands_cfg.blu_lo && h < bands_cfg.blu_hi) res.cls = CLS_BLUE;
    else res.cls = CLS_NONE;
    res.hue = h[HUE_W-1:0];
    res.sat = s[SAT_W-1:0];
    res.bright = mx[CH_W-1:0];
    return res;
  endfunction

  // Driver: load the next sample, wait out its gap, hold start until the transfer
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (start && took) begin
      nxt_start = 1'b0;
      have_cur = 1'b0;
    end
    if (!have_cur && pending_samples.size() != 0) begin
      cur_sample = pending_samples.pop_front();
      have_cur = 1'b1;
      gap_left = cur_sample.gap;
    end
    if (have_cur && !nxt_start) begin
      if (gap_left == 0) begin
        nxt_start = 1'b1;
        in_raw_red <= cur_sample.r;
        in_raw_green <= cur_sample.g;
        in_raw_blue <= cur_sample.b;
      end else begin
        gap_left = gap_left - 1;
      end
    end
    start <= nxt_start;
  end

  // Monitor: predict on each input transfer, check each result against the oldest prediction
  always @(posedge clk) begin
    hsv_result_t want;
    took <= rst_n && start && !busy;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_hsv.size() == 0) begin
        note_failure($sformatf("unexpected result cls=%0d hue=%0d sat=%0d bright=%0d",
                               out_color_class, out_hue, out_saturation, out_brightness));
      end else begin
        want = expected_hsv.pop_front();
        if (out_color_class !== want.cls || out_hue !== want.hue ||
            out_saturation !== want.sat || out_brightness !== want.bright)
          note_failure($sformatf({"mismatch exp cls=%0d hue=%0d sat=%0d bright=%0d",
                                  " got cls=%0d hue=%0d sat=%0d bright=%0d"},
                                 want.cls, want.hue, want.sat, want.bright,
                                 out_color_class, out_hue, out_saturation, out_brightness));
      end
    end
    if (rst_n && start && !busy)
      expected_hsv.push_back(classify_sample(in_raw_red, in_raw_green, in_raw_blue));
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_write(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic queue_sample(input u32_t r, input u32_t g, input u32_t b, input u32_t gap);
    sample_t s;
    s.r = r[RAW_W-1:0];
    s.g = g[RAW_W-1:0];
    s.b = b[RAW_W-1:0];
    s.gap = gap;
    pending_samples.push_back(s);
  endtask

  // Wait until every sample is sent and every result is back; drop what never comes
  task automatic drain_results();
    int waited;
    waited = 0;
    @(posedge clk);
    #1;
    while (pending_samples.size() != 0 || have_cur || start) begin
      @(posedge clk);
      #1;
    end
    while (expected_hsv.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      #1;
      waited++;
    end
    if (expected_hsv.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_hsv.size()));
      expected_hsv.delete();
    end
  endtask

  task automatic run_random(input int n);
    int   k, mode, kind;
    u32_t r, g, b, v, gap;
    for (k = 0; k < n; k++) begin
      gap = (k % 60 < 20) ? 0 : $urandom_range(0, 8);
      mode = $urandom_range(0, 9);
      r = $urandom_range(0, 1023);
      g = $urandom_range(0, 1023);
      b = $urandom_range(0, 1023);
      case (mode)
        6: begin
          r = $urandom_range(0, 15);
          g = $urandom_range(0, 15);
          b = $urandom_range(0, 15);
        end
        7: begin
          // tie on some pair or on all three channels
          kind = $urandom_range(0, 3);
          v = $urandom_range(0, 1023);
          case (kind)
            0: begin r = v; g = v; end
            1: begin g = v; b = v; end
            2: begin r = v; b = v; end
            default: begin r = v; g = v; b = v; end
          endcase
        end
        8: begin
          r = $urandom_range(0, 1) ? 1023 : 0;
          g = $urandom_range(0, 1) ? 1023 : 0;
          b = $urandom_range(0, 1) ? 1023 : 0;
        end
        9: begin
          // nearly grey: small deltas stress the rounding of the hue
          v = $urandom_range(4, 1019);
          r = v + $urandom_range(0, 4) - 2;
          g = v + $urandom_range(0, 4) - 2;
          b = v + $urandom_range(0, 4) - 2;
        end
        default: ;
      endcase
      queue_sample(r, g, b, gap);
    end
  endtask

  function automatic logic [63:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 64'd4096;
      1: return 64'($urandom_range(0, 8191));
      2: return 64'hFFFF;
      3: return 64'd0;
      default: return 64'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'd5760;
      2: return 64'd8191;
      3: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 5760));
    endcase
  endfunction

  initial begin
    int ph;
    gains_cfg = GAINS_RST;
    bands_cfg = '{red_lo: RED_LO_RST, red_hi: RED_HI_RST, grn_lo: GRN_LO_RST,
                  grn_hi: GRN_HI_RST, blu_lo: BLU_LO_RST, blu_hi: BLU_HI_RST};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    #1;

    // Reset bands and unity gains: grey, black, ties, band edges, wrap below zero
    queue_sample(0, 0, 0, $urandom_range(0, 8));
    queue_sample(1023, 1023, 1023, $urandom_range(0, 8));
    queue_sample(1023, 0, 0, $urandom_range(0, 8));
    queue_sample(0, 1023, 0, 0);
    queue_sample(0, 0, 1023, 0);
    queue_sample(200, 100, 0, $urandom_range(0, 8));
    queue_sample(200, 0, 100, $urandom_range(0, 8));
    queue_sample(0, 100, 100, 0);
    queue_sample(0, 50, 100, 0);
    queue_sample(100, 100, 0, $urandom_range(0, 8));
    queue_sample(100, 0, 100, 0);
    queue_sample(100, 100, 100, 0);
    queue_sample(300, 0, 1, $urandom_range(0, 8));
    queue_sample(1023, 1022, 0, 0);
    queue_sample(1, 0, 0, 0);
    queue_sample(0, 1, 1, $urandom_range(0, 8));
    drain_results();

    // Uneven gains, moderate bands, one write outside the register list
    write_reg(REG_GAINS, 64'h0000_2000_0800_1800);
    write_reg(REG_RED_LO, 64'd300);
    write_reg(REG_RED_HI, 64'd5500);
    write_reg(REG_GRN_LO, 64'd1000);
    write_reg(REG_GRN_HI, 64'd3000);
    write_reg(REG_BLU_LO, 64'd2500);
    write_reg(REG_BLU_HI, 64'd4800);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    #1;
    run_random(300);
    drain_results();

    // Full-scale gains, bands at the register extremes, upper data bits set
    write_reg(REG_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_RED_LO, 64'd0);
    write_reg(REG_RED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_GRN_LO, 64'd0);
    write_reg(REG_GRN_HI, 64'd8191);
    write_reg(REG_BLU_LO, 64'd5760);
    write_reg(REG_BLU_HI, 64'd0);
    @(posedge clk);
    #1;
    queue_sample(1023, 1023, 1023, 0);
    queue_sample(1023, 0, 0, 0);
    queue_sample(0, 1023, 0, $urandom_range(0, 8));
    queue_sample(0, 0, 1023, 0);
    queue_sample(0, 0, 0, 0);
    run_random(250);
    drain_results();

    // Zero gains: every sample is black
    write_reg(REG_GAINS, 64'd0);
    write_reg(REG_RED_LO, 64'd1);
    write_reg(REG_RED_HI, 64'd5760);
    @(posedge clk);
    #1;
    run_random(50);
    drain_results();

    // Random settings
    for (ph = 0; ph < 5; ph++) begin
      write_reg(REG_GAINS, {16'($urandom), 16'(pick_gain()), 16'(pick_gain()),
                            16'(pick_gain())});
      write_reg(REG_RED_LO, pick_bound());
      write_reg(REG_RED_HI, pick_bound());
      write_reg(REG_GRN_LO, pick_bound());
      write_reg(REG_GRN_HI, pick_bound());
      write_reg(REG_BLU_LO, pick_bound());
      write_reg(REG_BLU_HI, pick_bound());
      @(posedge clk);
      #1;
      run_random(110);
      drain_results();
    end

    // Let any stray result show up before the verdict
    repeat (30) @(posedge clk);
    #1;
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> rgb_hue_color_classifier.f
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div_cell.sv
rtl/core/rhc_back.sv
rtl/core/rgb_hue_color_classifier.sv
rtl/core/rhc_prop_chk.sv
tb/tb.sv
